FILE: sv/ip_prefix_allow_deny_filter_assert.svh
// assertion macros for the prefix filter
`ifndef IP_PREFIX_ALLOW_DENY_FILTER_ASSERT_SVH
`define IP_PREFIX_ALLOW_DENY_FILTER_ASSERT_SVH

// same-cycle implication, disabled while reset is high
`define IPF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("prefix filter assertion failed");

// next-cycle implication, disabled while reset is high
`define IPF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("prefix filter assertion failed");

`endif

FILE: sv/ipf_pkg.sv
// ----------------------------------------------------------------------------
// ipf_pkg
// shared types and constants of the prefix allow/deny filter
// ----------------------------------------------------------------------------
package ipf_pkg;

   localparam int RULES_PER_LIST = 16;
   localparam int IDX_W = (RULES_PER_LIST > 1) ? $clog2(RULES_PER_LIST) : 1;
   localparam int CNT_W = $clog2(RULES_PER_LIST + 1);

   localparam int REQ_TDATA_W = 136;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 8;

   localparam int FIFO_DEPTH = 2;
   localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] KIND_CHECK     = 2'd0;
   localparam logic [1:0] KIND_ADD_ALLOW = 2'd1;
   localparam logic [1:0] KIND_ADD_DENY  = 2'd2;

   localparam logic [7:0] V4_PREFIX_MAX = 8'd32;
   localparam logic [7:0] V6_PREFIX_MAX = 8'd128;
   localparam logic [7:0] MAPPED_OFFSET = 8'd96;
   localparam logic [31:0] MAPPED_TAG   = 32'h0000_ffff;

   localparam int RSP_PERMIT_BIT = 0;
   localparam int RSP_STATUS_BIT = 1;

   typedef struct packed {
      logic [1:0]  kind;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic        is_v6;
      logic [7:0]  prefix_len;
   } cmd_type;

   typedef struct packed {
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic        is_v6;
      logic [7:0]  prefix_len;
   } rule_type;

endpackage

FILE: sv/ipf_front.sv
// ----------------------------------------------------------------------------
// ipf_front
// accepts request transfers, normalizes the address family and clips prefixes
// ----------------------------------------------------------------------------
module ipf_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // addr_hi [63:0], addr_lo [127:64], prefix_len [135:128]
   input  logic [ipf_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // kind [1:0], is_v6 [2]
   input  logic [ipf_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                               push_valid,
   input  logic                               push_ready,
   output ipf_pkg::cmd_type                   push_cmd
);
   import ipf_pkg::*;

   logic        valid_ff, valid_in;
   cmd_type     cmd_ff, cmd_in;
   logic        in_v6;
   logic [7:0]  in_prefix;
   logic [7:0]  cap;

   assign in_v6     = req_tuser[2];
   assign in_prefix = req_tdata[135:128];
   assign cap       = in_v6 ? V6_PREFIX_MAX : V4_PREFIX_MAX;

   assign req_tready = !valid_ff || push_ready;

   always_comb begin
      cmd_in.kind       = req_tuser[1:0];
      cmd_in.is_v6      = in_v6;
      // ipv4 keeps only the low 32 address bits
      cmd_in.addr_hi    = in_v6 ? req_tdata[63:0] : 64'd0;
      cmd_in.addr_lo    = in_v6 ? req_tdata[127:64] : {32'd0, req_tdata[95:64]};
      cmd_in.prefix_len = (in_prefix > cap) ? cap : in_prefix;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         cmd_ff <= cmd_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

endmodule

FILE: sv/ipf_fifo.sv
// ----------------------------------------------------------------------------
// ipf_fifo
// short command queue between the front and the match engine
// ----------------------------------------------------------------------------
module ipf_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  ipf_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output ipf_pkg::cmd_type pop_cmd
);
   import ipf_pkg::*;

   cmd_type                 mem_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]   count_ff;
   logic                    do_push, do_pop;

   assign push_ready = count_ff != FIFO_CNT_W'(FIFO_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/ipf_engine.sv
// ----------------------------------------------------------------------------
// ipf_engine
// rule tables, insert handling and the per-entry scan of both lists
// ----------------------------------------------------------------------------
module ipf_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop_ready,
   input  ipf_pkg::cmd_type                pop_cmd,
   input  logic                            order_mode,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ipf_pkg::RSP_TDATA_W-1:0] rsp_tdata
);
   import ipf_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_RESULT} state_type;

   state_type         state_ff;
   rule_type          allow_tab_ff [RULES_PER_LIST];
   rule_type          deny_tab_ff  [RULES_PER_LIST];
   rule_type          allow_rd_ff, deny_rd_ff;
   rule_type          chk_ff;
   rule_type          new_rule;
   logic [CNT_W-1:0]  allow_cnt_ff, deny_cnt_ff;
   logic [CNT_W-1:0]  idx_ff;
   logic              allow_live_ff, deny_live_ff;
   logic              scan_vld_ff;
   logic              hit_a_ff, hit_d_ff;
   logic              rsp_valid_ff, rsp_permit_ff, rsp_status_ff;
   logic              slot_free, do_pop;
   logic              allow_full, deny_full;
   logic              allow_wr, deny_wr;
   logic              rsp_load;

   function automatic logic rule_hit(rule_type a, rule_type r);
      logic         a_map, r_map;
      logic [7:0]   p;
      logic [5:0]   p4;
      logic [31:0]  m4;
      logic [127:0] m;
      logic [127:0] diff;
      logic         hit;
      a_map = (a.addr_hi == 64'd0) && (a.addr_lo[63:32] == MAPPED_TAG);
      r_map = (r.addr_hi == 64'd0) && (r.addr_lo[63:32] == MAPPED_TAG);
      diff  = {a.addr_hi, a.addr_lo} ^ {r.addr_hi, r.addr_lo};
      p     = r.prefix_len;
      // mapped v6 against v4: prefix counts from bit 96
      if (a.is_v6 != r.is_v6 && p > MAPPED_OFFSET) begin
         p = p - MAPPED_OFFSET;
      end
      p4 = (p > V4_PREFIX_MAX) ? 6'd32 : p[5:0];
      for (int j = 0; j < 32; j++) begin
         m4[j] = 6'(j) >= (6'd32 - p4);
      end
      for (int j = 0; j < 128; j++) begin
         m[j] = 8'(j) >= (V6_PREFIX_MAX - p);
      end
      if (a.is_v6 != r.is_v6) begin
         hit = (a.is_v6 ? a_map : r_map) && ((diff[31:0] & m4) == 32'd0);
      end else if (!a.is_v6) begin
         hit = (diff[31:0] & m4) == 32'd0;
      end else begin
         hit = (diff & m) == 128'd0;
      end
      return hit;
   endfunction

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign pop_ready  = (state_ff == ST_IDLE) && slot_free;
   assign do_pop     = pop_valid && pop_ready;
   assign allow_full = allow_cnt_ff == CNT_W'(RULES_PER_LIST);
   assign deny_full  = deny_cnt_ff == CNT_W'(RULES_PER_LIST);
   assign allow_wr   = do_pop && (pop_cmd.kind == KIND_ADD_ALLOW) && !allow_full;
   assign deny_wr    = do_pop && (pop_cmd.kind == KIND_ADD_DENY) && !deny_full;
   // a new result may load in the cycle the old one leaves
   assign rsp_load   = (do_pop && (pop_cmd.kind != KIND_CHECK)) ||
                       ((state_ff == ST_RESULT) && slot_free);

   always_comb begin
      new_rule.addr_hi    = pop_cmd.addr_hi;
      new_rule.addr_lo    = pop_cmd.addr_lo;
      new_rule.is_v6      = pop_cmd.is_v6;
      new_rule.prefix_len = pop_cmd.prefix_len;
   end

   // rule tables with registered read at the scan index
   always_ff @(posedge clock) begin
      if (allow_wr) begin
         allow_tab_ff[allow_cnt_ff[IDX_W-1:0]] <= new_rule;
      end
      if (deny_wr) begin
         deny_tab_ff[deny_cnt_ff[IDX_W-1:0]] <= new_rule;
      end
      allow_rd_ff   <= allow_tab_ff[idx_ff[IDX_W-1:0]];
      deny_rd_ff    <= deny_tab_ff[idx_ff[IDX_W-1:0]];
      allow_live_ff <= idx_ff < allow_cnt_ff;
      deny_live_ff  <= idx_ff < deny_cnt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         allow_cnt_ff <= '0;
         deny_cnt_ff  <= '0;
         idx_ff       <= '0;
         scan_vld_ff  <= 1'b0;
         hit_a_ff     <= 1'b0;
         hit_d_ff     <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         scan_vld_ff <= state_ff == ST_SCAN;
         // compare the entries read in the previous cycle
         if (scan_vld_ff) begin
            hit_a_ff <= hit_a_ff || (allow_live_ff && rule_hit(chk_ff, allow_rd_ff));
            hit_d_ff <= hit_d_ff || (deny_live_ff && rule_hit(chk_ff, deny_rd_ff));
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (do_pop) begin
                  case (pop_cmd.kind)
                     KIND_CHECK: begin
                        chk_ff   <= new_rule;
                        idx_ff   <= '0;
                        hit_a_ff <= 1'b0;
                        hit_d_ff <= 1'b0;
                        state_ff <= ST_SCAN;
                     end
                     KIND_ADD_ALLOW: begin
                        if (!allow_full) begin
                           allow_cnt_ff <= allow_cnt_ff + 1'b1;
                        end
                        rsp_permit_ff <= 1'b0;
                        rsp_status_ff <= allow_full;
                     end
                     KIND_ADD_DENY: begin
                        if (!deny_full) begin
                           deny_cnt_ff <= deny_cnt_ff + 1'b1;
                        end
                        rsp_permit_ff <= 1'b0;
                        rsp_status_ff <= deny_full;
                     end
                     default: begin
                        rsp_permit_ff <= 1'b0;
                        rsp_status_ff <= 1'b0;
                     end
                  endcase
               end
            end
            ST_SCAN: begin
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff == CNT_W'(RULES_PER_LIST - 1)) begin
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               state_ff <= ST_RESULT;
            end
            ST_RESULT: begin
               if (slot_free) begin
                  rsp_permit_ff <= order_mode ? (hit_a_ff && !hit_d_ff)
                                              : (hit_a_ff || !hit_d_ff);
                  rsp_status_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      rsp_tdata                 = '0;
      rsp_tdata[RSP_PERMIT_BIT] = rsp_permit_ff;
      rsp_tdata[RSP_STATUS_BIT] = rsp_status_ff;
   end

endmodule

FILE: sv/ip_prefix_allow_deny_filter.sv
// ----------------------------------------------------------------------------
// ip_prefix_allow_deny_filter
// allow/deny rule lists of ipv4/ipv6 prefixes with address checks
// ----------------------------------------------------------------------------
// engine use: a check holds the engine through pop, a scan of every entry
//   reading one entry of each list per cycle, drain and result; an insert
//   holds it only for its pop
// reset: rule counts and order mode clear at once; table contents are not
//   cleared and no clearing pass runs, entries above the count are never used
module ip_prefix_allow_deny_filter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // addr_hi [63:0], addr_lo [127:64], prefix_len [135:128]
   input  logic [ipf_pkg::REQ_TDATA_W-1:0] req_tdata,
   // kind [1:0], is_v6 [2]
   input  logic [ipf_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // permitted [0], status [1], zero [7:2]
   output logic [ipf_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic                            csr_data
);
   import ipf_pkg::*;

   `include "ip_prefix_allow_deny_filter_assert.svh"

   logic    order_mode_ff;
   logic    push_valid, push_ready;
   logic    pop_valid, pop_ready;
   cmd_type push_cmd, pop_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         order_mode_ff <= csr_data;
      end
   end

   ipf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   ipf_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   ipf_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd),
      .order_mode (order_mode_ff),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // a request transfer is held in the front stage on the next cycle
   `IPF_ASSERT_NEXT(a_req_lands, clock, reset, req_tvalid && req_tready, push_valid)
   // a stalled response keeps its valid and data
   `IPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `IPF_ASSERT_NOW(a_full_not_permit, clock, reset,
      rsp_tvalid && rsp_tdata[RSP_STATUS_BIT], !rsp_tdata[RSP_PERMIT_BIT])

endmodule
